@@ rtl/uhjt_pkg.sv @@
package uhjt_pkg;

	// Width of the running token counter; the counter saturates at its largest value.
	localparam int COUNT_BITS = 16;
	localparam int OUT_CNT_W  = 16;
	localparam int CMP_W      = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
	localparam int CP_W       = 21;
	localparam int OFF_W      = 14;
	localparam int TOKEN_W    = 7;
	localparam int PADDR_W    = 3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [OUT_CNT_W-1:0]  cnt_out_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [CP_W-1:0]       cp_t;
	typedef logic [OFF_W-1:0]      off_t;
	typedef logic [TOKEN_W-1:0]    token_t;
	typedef logic [4:0]            jamo_t;
	typedef logic [8:0]            q28_t;

	// Register map (byte addresses).
	localparam logic [PADDR_W-1:0] ADDR_TOKEN_BUDGET  = 3'h0;
	localparam logic [15:0]        TOKEN_BUDGET_RESET = 16'd1020;

	// Hangul syllable block.
	localparam cp_t CP_SYL_FIRST = 21'h00AC00;
	localparam cp_t CP_SYL_LAST  = 21'h00D7A3;

	// Punctuation code points.
	localparam cp_t CP_SPACE    = 21'h000020;
	localparam cp_t CP_PERIOD   = 21'h00002E;
	localparam cp_t CP_COMMA    = 21'h00002C;
	localparam cp_t CP_QUESTION = 21'h00003F;
	localparam cp_t CP_EXCLAIM  = 21'h000021;

	// Token codes.
	localparam token_t TOK_NONE     = 7'd0;
	localparam token_t TOK_PERIOD   = 7'd1;
	localparam token_t TOK_COMMA    = 7'd2;
	localparam token_t TOK_QUESTION = 7'd3;
	localparam token_t TOK_EXCLAIM  = 7'd4;
	localparam token_t TOK_SPACE    = 7'd6;
	localparam token_t INI_BASE     = 7'd7;
	localparam token_t MED_BASE     = 7'd26;
	localparam token_t FIN_BASE     = 7'd47;

	// UTF-8 lead byte classes.
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;

	// Reciprocals for the constant divisions: floor(x/7) for x < 2800 and
	// floor(y/21) for y < 400, both taken from the product's bits 15 and up.
	localparam logic [12:0] RECIP7  = 13'd4682;
	localparam logic [10:0] RECIP21 = 11'd1561;

	// Per-request metadata that travels down the pipeline beside the syllable offset.
	typedef struct packed {
		logic              done;
		logic              hangul;
		token_t            punct;
		logic [1:0]        n;
		cnt_out_t [2:0]    cnt;
	} meta_t;

	function automatic count_t sat_inc(input count_t c);
		sat_inc = (c == '1) ? c : count_t'(c + count_t'(1));
	endfunction

endpackage

@@ rtl/uhjt_syl_split.sv @@
// Splits a syllable offset (code point minus the block base) into initial,
// medial and final indexes. One register stage sits between the two constant
// multiplications.
module uhjt_syl_split (
	input  logic                 clk,
	input  logic                 en,
	input  uhjt_pkg::off_t       off_s2,
	output uhjt_pkg::jamo_t      ini,
	output uhjt_pkg::jamo_t      med,
	output uhjt_pkg::jamo_t      fin
);

	logic [24:0]      p7;
	uhjt_pkg::q28_t   q28;
	uhjt_pkg::q28_t   q28_s3;
	uhjt_pkg::off_t   off_s3;
	logic [19:0]      p21;
	logic [8:0]       ini21;
	uhjt_pkg::off_t   q28x28;

	// off / 28 = (off / 4) / 7
	assign p7  = 25'(off_s2[13:2]) * 25'(uhjt_pkg::RECIP7);
	assign q28 = p7[23:15];

	always_ff @(posedge clk) begin
		if (en) begin
			q28_s3 <= q28;
			off_s3 <= off_s2;
		end
	end

	assign p21    = 20'(q28_s3) * 20'(uhjt_pkg::RECIP21);
	assign ini    = p21[19:15];
	assign ini21  = {ini, 4'b0000} + 9'({ini, 2'b00}) + 9'(ini);
	assign med    = 5'(q28_s3 - ini21);
	assign q28x28 = 14'({q28_s3, 5'b00000}) - 14'({q28_s3, 2'b00});
	assign fin    = 5'(off_s3 - q28x28);

endmodule

@@ rtl/utf8_hangul_jamo_tokenizer_unit.sv @@
// UTF-8 Hangul jamo tokenizer. Text bytes enter on the s_ stream, one byte per
// request, with s_tlast marking end of text. Each completed character that was
// started while the token count was below token_budget yields tokens on the m_
// stream: a Hangul syllable gives an initial, a medial and (if present) a final
// token; space and . , ? ! give one token each; anything else gives nothing.
// End of text, or a zero byte at a character start, gives one result with
// m_tuser set, token_id 0 and the final count, and then clears the text state.
// The block takes one byte per cycle while the output does not stall it. A
// request that yields two or three tokens hands them out one after another, and
// the input stalls when a group waits behind the three-entry result buffer while
// it is still draining; the buffer loads its next group in the same cycle its
// last result leaves. A byte passes four registers on its way out: the input
// register, character decode and count update, the first divide-by-constant
// stage, and the result buffer. The input register loads at the accepting edge.
// Configuration: token_budget at byte address 0 of the APB port; write it only
// while the block is idle.
module utf8_hangul_jamo_tokenizer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [uhjt_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// Text byte stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] text_byte
	input  logic                           s_tlast,   // end_of_text
	// Token stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [6:0] token_id, [22:7] token_count, [23] zero
	output logic                           m_tlast,   // last_of_run
	output logic                           m_tuser    // done_res
);

	// Configuration register.
	logic [15:0] budget_q;

	// Text state.
	uhjt_pkg::cp_t    pcp_q;
	logic [1:0]       rem_q;
	uhjt_pkg::count_t cnt_q;
	logic             acc_q;

	// Pipeline.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;
	logic             valid_s2;
	uhjt_pkg::meta_t  meta_s2;
	uhjt_pkg::off_t   off_s2;
	logic             valid_s3;
	uhjt_pkg::meta_t  meta_s3;

	// Result buffer.
	logic               buf_v_q;
	logic [1:0]         buf_idx_q;
	uhjt_pkg::meta_t    buf_meta_q;
	uhjt_pkg::token_t   buf_tok_q [3];

	// Decode stage signals.
	uhjt_pkg::cp_t    pcp_n;
	logic [1:0]       rem_n;
	uhjt_pkg::count_t cnt_n;
	logic             acc_n;
	logic             eot_hit;
	uhjt_pkg::cp_t    cp;
	uhjt_pkg::cp_t    off_full;
	uhjt_pkg::off_t   off;
	logic [4:0]       mod7_sum;
	logic [3:0]       mod7_fold;
	logic             fin_nz;
	uhjt_pkg::count_t c1, c2, c3;
	uhjt_pkg::meta_t  meta_n;

	// Split results and tokens.
	uhjt_pkg::jamo_t  ini, med, fin;
	uhjt_pkg::token_t tok0, tok1, tok2;

	logic adv;
	logic take;
	logic last_take;
	logic buf_free;
	logic cfg_wr;

	// ------------------------------------------------------------------
	// Configuration port. Only bit 2 of the address selects a register;
	// the byte-lane bits are ignored.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= uhjt_pkg::TOKEN_BUDGET_RESET;
		end else if (cfg_wr && paddr[2] == uhjt_pkg::ADDR_TOKEN_BUDGET[2]) begin
			budget_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == uhjt_pkg::ADDR_TOKEN_BUDGET[2]) ? {16'b0, budget_q} : 32'b0;

	// ------------------------------------------------------------------
	// Flow control. The whole pipeline moves together; it stalls only when
	// the last stage holds a group and the result buffer cannot take it.
	// ------------------------------------------------------------------
	assign take      = m_tvalid && m_tready;
	assign last_take = take && m_tlast;
	assign buf_free  = !buf_v_q || last_take;
	assign adv       = !valid_s3 || buf_free;
	assign s_tready  = adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Character decode, classification and count update. The count must be
	// settled here because the next lead byte compares it against the budget.
	// Whether a syllable has a final consonant is found from offset mod 4 and
	// offset mod 7, so no division is needed here.
	// ------------------------------------------------------------------
	assign c1 = uhjt_pkg::sat_inc(cnt_q);
	assign c2 = uhjt_pkg::sat_inc(c1);
	assign c3 = uhjt_pkg::sat_inc(c2);

	always_comb begin
		pcp_n     = pcp_q;
		rem_n     = rem_q;
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		cp        = '0;
		eot_hit   = eot_s1 || (rem_q == 2'd0 && byte_s1 == 8'h00);
		meta_n    = '0;
		meta_n.punct = uhjt_pkg::TOK_NONE;
		meta_n.cnt[0] = uhjt_pkg::cnt_out_t'(c1);
		meta_n.cnt[1] = uhjt_pkg::cnt_out_t'(c2);
		meta_n.cnt[2] = uhjt_pkg::cnt_out_t'(c3);

		off_full  = cp - uhjt_pkg::CP_SYL_FIRST;
		off       = off_full[13:0];
		mod7_sum  = 5'(off[2:0]) + 5'(off[5:3]) + 5'(off[8:6]) + 5'(off[11:9])
		          + 5'(off[13:12]);
		mod7_fold = 4'(mod7_sum[2:0]) + 4'(mod7_sum[4:3]);
		fin_nz    = 1'b1;

		if (eot_hit) begin
			meta_n.done   = 1'b1;
			meta_n.n      = 2'd1;
			meta_n.cnt[0] = uhjt_pkg::cnt_out_t'(cnt_q);
			pcp_n = '0;
			rem_n = 2'd0;
			acc_n = 1'b0;
			cnt_n = '0;
		end else begin
			if (rem_q != 2'd0) begin
				// Continuation bytes are taken as they come, without checks.
				pcp_n = {pcp_q[14:0], byte_s1[5:0]};
				rem_n = rem_q - 2'd1;
			end else begin
				acc_n = uhjt_pkg::cmp_t'(cnt_q) < uhjt_pkg::cmp_t'(budget_q);
				if (byte_s1[7] == 1'b0) begin
					pcp_n = uhjt_pkg::cp_t'(byte_s1);
					rem_n = 2'd0;
				end else if ((byte_s1 & uhjt_pkg::LEAD2_MASK) == uhjt_pkg::LEAD2_VAL) begin
					pcp_n = uhjt_pkg::cp_t'(byte_s1[4:0]);
					rem_n = 2'd1;
				end else if ((byte_s1 & uhjt_pkg::LEAD3_MASK) == uhjt_pkg::LEAD3_VAL) begin
					pcp_n = uhjt_pkg::cp_t'(byte_s1[3:0]);
					rem_n = 2'd2;
				end else if ((byte_s1 & uhjt_pkg::LEAD4_MASK) == uhjt_pkg::LEAD4_VAL) begin
					pcp_n = uhjt_pkg::cp_t'(byte_s1[2:0]);
					rem_n = 2'd3;
				end else begin
					// A stray continuation byte or an invalid lead byte is a
					// one-byte character with code point zero.
					pcp_n = '0;
					rem_n = 2'd0;
				end
			end

			if (rem_n == 2'd0) begin
				cp        = pcp_n;
				off_full  = cp - uhjt_pkg::CP_SYL_FIRST;
				off       = off_full[13:0];
				mod7_sum  = 5'(off[2:0]) + 5'(off[5:3]) + 5'(off[8:6]) + 5'(off[11:9])
				          + 5'(off[13:12]);
				mod7_fold = 4'(mod7_sum[2:0]) + 4'(mod7_sum[4:3]);
				fin_nz    = !(off[1:0] == 2'd0 && (mod7_fold == 4'd0 || mod7_fold == 4'd7));
				if (acc_n) begin
					if (cp >= uhjt_pkg::CP_SYL_FIRST && cp <= uhjt_pkg::CP_SYL_LAST) begin
						meta_n.hangul = 1'b1;
						meta_n.n      = fin_nz ? 2'd3 : 2'd2;
					end else if (cp == uhjt_pkg::CP_SPACE) begin
						meta_n.punct = uhjt_pkg::TOK_SPACE;
						meta_n.n     = 2'd1;
					end else if (cp == uhjt_pkg::CP_PERIOD) begin
						meta_n.punct = uhjt_pkg::TOK_PERIOD;
						meta_n.n     = 2'd1;
					end else if (cp == uhjt_pkg::CP_COMMA) begin
						meta_n.punct = uhjt_pkg::TOK_COMMA;
						meta_n.n     = 2'd1;
					end else if (cp == uhjt_pkg::CP_QUESTION) begin
						meta_n.punct = uhjt_pkg::TOK_QUESTION;
						meta_n.n     = 2'd1;
					end else if (cp == uhjt_pkg::CP_EXCLAIM) begin
						meta_n.punct = uhjt_pkg::TOK_EXCLAIM;
						meta_n.n     = 2'd1;
					end
				end
				pcp_n = '0;
				acc_n = 1'b0;
				case (meta_n.n)
					2'd1:    cnt_n = c1;
					2'd2:    cnt_n = c2;
					2'd3:    cnt_n = c3;
					default: cnt_n = cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcp_q <= '0;
			rem_q <= 2'd0;
			cnt_q <= '0;
			acc_q <= 1'b0;
		end else if (adv && valid_s1) begin
			pcp_q <= pcp_n;
			rem_q <= rem_n;
			cnt_q <= cnt_n;
			acc_q <= acc_n;
		end
	end

	// Requests that yield no result drop out here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && (meta_n.n != 2'd0);
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_n;
			off_s2  <= off;
			meta_s3 <= meta_s2;
		end
	end

	uhjt_syl_split u_split (
		.clk    (clk),
		.en     (adv),
		.off_s2 (off_s2),
		.ini    (ini),
		.med    (med),
		.fin    (fin)
	);

	assign tok0 = meta_s3.done   ? uhjt_pkg::TOK_NONE :
	              meta_s3.hangul ? uhjt_pkg::token_t'(uhjt_pkg::INI_BASE + 7'(ini)) :
	                               meta_s3.punct;
	assign tok1 = uhjt_pkg::token_t'(uhjt_pkg::MED_BASE + 7'(med));
	assign tok2 = uhjt_pkg::token_t'(uhjt_pkg::FIN_BASE + 7'(fin) - 7'd1);

	// ------------------------------------------------------------------
	// Result buffer: holds one request's group of up to three results and
	// hands them out in order.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_v_q   <= 1'b0;
			buf_idx_q <= 2'd0;
		end else if (valid_s3 && buf_free) begin
			buf_v_q   <= 1'b1;
			buf_idx_q <= 2'd0;
		end else if (last_take) begin
			buf_v_q   <= 1'b0;
		end else if (take) begin
			buf_idx_q <= buf_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && buf_free) begin
			buf_meta_q   <= meta_s3;
			buf_tok_q[0] <= tok0;
			buf_tok_q[1] <= tok1;
			buf_tok_q[2] <= tok2;
		end
	end

	assign m_tvalid = buf_v_q;
	assign m_tlast  = (buf_idx_q == buf_meta_q.n - 2'd1);
	assign m_tuser  = buf_meta_q.done;

	always_comb begin
		case (buf_idx_q)
			2'd0:    m_tdata = {1'b0, buf_meta_q.cnt[0], buf_tok_q[0]};
			2'd1:    m_tdata = {1'b0, buf_meta_q.cnt[1], buf_tok_q[1]};
			default: m_tdata = {1'b0, buf_meta_q.cnt[2], buf_tok_q[2]};
		endcase
	end

`ifndef SYNTH
	// The buffer never points past the group it holds.
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		buf_v_q |-> (buf_idx_q < buf_meta_q.n))
		else $error("result index beyond group size");

	// End of text leaves the text state cleared.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && eot_hit) |=> (cnt_q == '0 && rem_q == 2'd0 && !acc_q))
		else $error("text state not cleared after end of text");

	// A full buffer with a group waiting behind it must stall the input.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_v_q && !m_tready && valid_s3) |-> !s_tready)
		else $error("input accepted while pipeline is blocked");

	// Only the end-of-text result carries token zero.
	a_token_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[6:0] != uhjt_pkg::TOK_NONE))
		else $error("zero token on a regular result");
`endif

endmodule
